### rtl/mlbt_pkg.sv
// Shared types and codes for the multi-channel LED blink timer.
package mlbt_pkg;

    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [3:0] led_index;
        logic [7:0] delay_ticks;
        logic [7:0] toggle_period;
    } in_word_t;

    typedef struct packed {
        logic [3:0] led_number;
        logic       led_on;
        logic       last;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } mlbt_state_t;

endpackage

### rtl/mlbt_ram.sv
// Generic simple dual-port RAM with registered read.
module mlbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/multi_led_blink_timer_unit.sv
// Top level of the multi-channel LED blink timer: scan control and output word.
//
//  channel | signals                     | word
//  --------+-----------------------------+-----------------------------
//  in      | in_valid / in_ready         | in_word  (kind, index, delay, period)
//  out     | out_valid / out_ready       | out_word (led_number, led_on, last)
//
// Set word: needs a free output register; an in-range index loads its event at the accepting edge.
// Tick word: in_ready stays low until the scan ends: the RAM read is registered, the scan
// takes one channel per cycle unless stalled, then the scan ends and the held event is flushed.
// One event is held back so the final one can be flagged last; an expiry that finds the
// held event blocked by a full output register stalls the scan.
// Reset: RAM valid bits clear, so all channels read zero.
module multi_led_blink_timer_unit #(
    parameter int CHANNELS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mlbt_pkg::in_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output mlbt_pkg::out_word_t out_word
);

    import mlbt_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    mlbt_state_t      state_reg, state_next;

    logic [CNT_W-1:0] rd_idx_reg;
    logic             eval_valid_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic             pend_valid_reg;
    logic [3:0]       pend_num_reg;
    logic             pend_on_reg;
    logic             out_valid_reg;
    out_word_t        out_word_reg;
    logic [CHANNELS-1:0] cnt_vld_reg;
    logic [CHANNELS-1:0] ph_vld_reg;

    logic             in_acc;
    logic             tick_start;
    logic             in_range;
    logic             out_free;
    logic             scan_done;
    logic             more_to_read;

    logic [15:0]      cnt_rd;
    logic [0:0]       ph_rd;
    logic [7:0]       cur_cnt;
    logic [7:0]       cur_rel;
    logic             cur_ph;
    logic [7:0]       dec_cnt;
    logic             active;
    logic             hit;
    logic             ev_on;
    logic             stall;

    logic             cnt_we;
    logic [IDX_W-1:0] cnt_waddr;
    logic [15:0]      cnt_wdata;
    logic             ph_we;
    logic [0:0]       ph_wdata;
    logic             rd_en;
    logic             out_load;
    out_word_t        out_load_word;

    mlbt_ram #(
        .WIDTH (16),
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (cnt_rd)
    );

    mlbt_ram #(
        .WIDTH (1),
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_ph_ram (
        .clk     (clk),
        .wr_en   (ph_we),
        .wr_addr (eval_idx_reg),
        .wr_data (ph_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (ph_rd)
    );

    assign in_acc       = in_valid && in_ready;
    assign tick_start   = in_acc && (in_word.kind == KIND_TICK);
    assign in_range     = ({1'b0, in_word.led_index} < 5'(CHANNELS));
    assign out_free     = !out_valid_reg || out_ready;
    assign more_to_read = (rd_idx_reg < CNT_W'(CHANNELS));
    assign scan_done    = !more_to_read && !eval_valid_reg;

    assign cur_cnt = cnt_vld_reg[eval_idx_reg] ? cnt_rd[15:8] : 8'd0;
    assign cur_rel = cnt_vld_reg[eval_idx_reg] ? cnt_rd[7:0] : 8'd0;
    assign cur_ph  = ph_vld_reg[eval_idx_reg] ? ph_rd[0] : 1'b0;
    assign dec_cnt = cur_cnt - 8'd1;
    assign active  = (state_reg == ST_SCAN) && eval_valid_reg && (cur_cnt != 8'd0);
    assign hit     = active && (dec_cnt == 8'd0);
    assign ev_on   = (cur_rel != 8'd0) ? cur_ph : 1'b0;
    assign stall   = hit && pend_valid_reg && !out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cnt_we        = 1'b0;
        cnt_waddr     = eval_idx_reg;
        cnt_wdata     = 16'd0;
        ph_we         = 1'b0;
        ph_wdata      = ~cur_ph;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        out_load_word = '{led_number: pend_num_reg, led_on: pend_on_reg, last: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_acc && (in_word.kind == KIND_SET) && in_range)
                begin
                    cnt_we        = 1'b1;
                    cnt_waddr     = in_word.led_index[IDX_W-1:0];
                    cnt_wdata     = {in_word.delay_ticks, in_word.toggle_period};
                    out_load      = 1'b1;
                    out_load_word = '{led_number: in_word.led_index, led_on: 1'b1,
                                      last: 1'b1};
                end
            end
            ST_SCAN:
            begin
                rd_en = !stall && more_to_read;
                if (active && !stall)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = {(hit && (cur_rel != 8'd0)) ? cur_rel : dec_cnt, cur_rel};
                    ph_we     = hit && (cur_rel != 8'd0);
                end
                if (hit && pend_valid_reg && !stall)
                begin
                    out_load = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    out_load           = 1'b1;
                    out_load_word.last = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_idx_reg     <= '0;
            eval_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_vld_reg    <= '0;
            ph_vld_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (tick_start)
            begin
                rd_idx_reg     <= '0;
                eval_valid_reg <= 1'b0;
            end
            else if ((state_reg == ST_SCAN) && !stall)
            begin
                eval_valid_reg <= rd_en;
                if (rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end

            if (hit && !stall)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if ((state_reg == ST_FLUSH) && out_load)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (cnt_we)
            begin
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            end
            if (ph_we)
            begin
                ph_vld_reg[eval_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg <= out_load_word;
        end
        if (rd_en)
        begin
            eval_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (hit && !stall)
        begin
            pend_num_reg <= 4'(eval_idx_reg);
            pend_on_reg  <= ev_on;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE) && !pend_valid_reg)
        else $error("input taken while a scan or held event is in flight");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> eval_valid_reg && $stable(eval_idx_reg) && $stable(rd_idx_reg))
        else $error("scan moved during an output stall");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= CNT_W'(CHANNELS))
        else $error("scan index past channel count");

    a_flush_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) && (state_next == ST_IDLE) |=> !pend_valid_reg)
        else $error("held event dropped at end of scan");

endmodule
